/* rtl/two_way_word_instruction_cache_defines.svh */
// Assertion macros shared by the instruction cache files.
// The clock is clk and the active-low synchronous reset is rst_n in every user.
`ifndef TWO_WAY_WORD_INSTRUCTION_CACHE_DEFINES_SVH
`define TWO_WAY_WORD_INSTRUCTION_CACHE_DEFINES_SVH

`ifndef SYNTHESIS
// Checked only while out of reset.
`define TWWIC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Checked at every edge, including during reset.
`define TWWIC_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define TWWIC_ASSERT(lbl, prop, msg)
`define TWWIC_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

/* rtl/twwic_pkg.sv */
`default_nettype none

package twwic_pkg;

  // Fixed field widths.
  localparam int ADDR_W             = 32;
  localparam int WORD_W             = 32;
  localparam int OFFSET_BITS        = 2;
  localparam int SET_INDEX_BITS_DEF = 13;

  // Per-set metadata: valid bit of way 0, valid bit of way 1, last filled way.
  localparam int META_W    = 3;
  localparam int META_V0   = 0;
  localparam int META_V1   = 1;
  localparam int META_LAST = 2;

  // One fetch as held in the queue between front and back.
  typedef struct packed {
    logic [ADDR_W-1:0] fetch_address;
    logic [WORD_W-1:0] memory_word;
  } fetch_t;

  // Queue head as seen by the back end.
  typedef struct packed {
    logic   head_valid;
    fetch_t head;
  } front_stat_t;

  // Back end control toward the front end.
  typedef struct packed {
    logic pop;
    logic clearing;
  } back_ctl_t;

endpackage

`default_nettype wire

/* rtl/twwic_fetch_if.sv */
`default_nettype none

interface twwic_fetch_if;
  logic        valid;
  logic        ready;
  logic [31:0] fetch_address;
  logic [31:0] memory_word;

  modport source (output valid, output fetch_address, output memory_word, input ready);
  modport sink   (input valid, input fetch_address, input memory_word, output ready);
endinterface

`default_nettype wire

/* rtl/twwic_result_if.sv */
`default_nettype none

interface twwic_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_word;
  logic        was_hit;

  modport source (output valid, output read_word, output was_hit, input ready);
  modport sink   (input valid, input read_word, input was_hit, output ready);
endinterface

`default_nettype wire

/* rtl/twwic_ram.sv */
`default_nettype none

module twwic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port; read data holds between reads.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/twwic_front.sv */
`default_nettype none

module twwic_front (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  twwic_fetch_if.sink                 in_fetch,
  input  wire twwic_pkg::back_ctl_t   ctl,
  output twwic_pkg::front_stat_t      stat
);

  import twwic_pkg::*;

  // Two-entry queue of accepted fetches.
  fetch_t     q_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push;
  logic       pop;

  // No item is taken while the metadata clearing pass runs.
  assign in_fetch.ready = (cnt_r != 2'd2) && !ctl.clearing;
  assign push           = in_fetch.valid && in_fetch.ready;
  assign pop            = ctl.pop && (cnt_r != 2'd0);

  assign stat.head_valid = (cnt_r != 2'd0);
  assign stat.head       = q_r[rd_ptr_r];

  // Pointer and fill count updates.
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop  ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Queue payload storage.
  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= '{fetch_address: in_fetch.fetch_address,
                         memory_word:   in_fetch.memory_word};
    end
  end

endmodule

`default_nettype wire

/* rtl/twwic_back.sv */
`default_nettype none

module twwic_back #(
  parameter int SET_INDEX_BITS = twwic_pkg::SET_INDEX_BITS_DEF
) (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire twwic_pkg::front_stat_t                 stat,
  output twwic_pkg::back_ctl_t                        ctl,
  twwic_result_if.source                              out_result,
  // Shared read port of all memories.
  output logic                                        rd_en,
  output logic [SET_INDEX_BITS-1:0]                   rd_addr,
  // Shared write address.
  output logic [SET_INDEX_BITS-1:0]                   wr_addr,
  output logic                                        meta_we,
  output logic [twwic_pkg::META_W-1:0]                meta_wdata,
  input  wire logic [twwic_pkg::META_W-1:0]           meta_rdata,
  output logic                                        way0_we,
  output logic                                        way1_we,
  output logic [twwic_pkg::ADDR_W-twwic_pkg::OFFSET_BITS-SET_INDEX_BITS+
                twwic_pkg::WORD_W-1:0]                way_wdata,
  input  wire logic [twwic_pkg::ADDR_W-twwic_pkg::OFFSET_BITS-SET_INDEX_BITS+
                     twwic_pkg::WORD_W-1:0]           way0_rdata,
  input  wire logic [twwic_pkg::ADDR_W-twwic_pkg::OFFSET_BITS-SET_INDEX_BITS+
                     twwic_pkg::WORD_W-1:0]           way1_rdata
);

  import twwic_pkg::*;

  localparam int TAG_W = ADDR_W - OFFSET_BITS - SET_INDEX_BITS;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_COMPARE
  } state_t;

  state_t                    state_r, state_nxt;
  logic [SET_INDEX_BITS-1:0] clr_cnt_r, clr_cnt_nxt;
  fetch_t                    cur_r, cur_nxt;
  logic                      out_valid_r, out_valid_nxt;
  logic [WORD_W-1:0]         out_word_r, out_word_nxt;
  logic                      out_hit_r, out_hit_nxt;

  logic [SET_INDEX_BITS-1:0] cur_set;
  logic [TAG_W-1:0]          cur_tag;
  logic                      v0, v1, last;
  logic                      hit0, hit1, fill0;
  logic                      slot_free;

  assign cur_set = cur_r.fetch_address[OFFSET_BITS +: SET_INDEX_BITS];
  assign cur_tag = cur_r.fetch_address[ADDR_W-1 -: TAG_W];

  // Tag compare and replacement choice on the registered memory data.
  assign v0    = meta_rdata[META_V0];
  assign v1    = meta_rdata[META_V1];
  assign last  = meta_rdata[META_LAST];
  assign hit0  = v0 && (way0_rdata[WORD_W +: TAG_W] == cur_tag);
  assign hit1  = v1 && (way1_rdata[WORD_W +: TAG_W] == cur_tag) && !hit0;
  assign fill0 = !v0 || (v1 && last);

  assign slot_free = !out_valid_r || out_result.ready;

  assign out_result.valid     = out_valid_r;
  assign out_result.read_word = out_word_r;
  assign out_result.was_hit   = out_hit_r;

  assign ctl.clearing = (state_r == S_CLEAR);
  assign ctl.pop      = (state_r == S_IDLE) && stat.head_valid;

  // Lookup read of the queue head, issued as it is popped.
  assign rd_en   = ctl.pop;
  assign rd_addr = stat.head.fetch_address[OFFSET_BITS +: SET_INDEX_BITS];

  assign way_wdata = {cur_tag, cur_r.memory_word};

  // Sequencer: clearing pass, then lookup and compare-and-fill per item.
  always_comb begin
    state_nxt     = state_r;
    clr_cnt_nxt   = clr_cnt_r;
    cur_nxt       = cur_r;
    out_valid_nxt = out_valid_r && !out_result.ready;
    out_word_nxt  = out_word_r;
    out_hit_nxt   = out_hit_r;
    wr_addr       = cur_set;
    meta_we       = 1'b0;
    meta_wdata    = '0;
    way0_we       = 1'b0;
    way1_we       = 1'b0;
    case (state_r)
      S_CLEAR: begin
        wr_addr     = clr_cnt_r;
        meta_we     = 1'b1;
        clr_cnt_nxt = clr_cnt_r + 1'b1;
        if (&clr_cnt_r) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (stat.head_valid) begin
          cur_nxt   = stat.head;
          state_nxt = S_COMPARE;
        end
      end
      S_COMPARE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = hit0 || hit1;
          if (hit0) begin
            out_word_nxt = way0_rdata[WORD_W-1:0];
          end else if (hit1) begin
            out_word_nxt = way1_rdata[WORD_W-1:0];
          end else begin
            out_word_nxt          = cur_r.memory_word;
            meta_we               = 1'b1;
            way0_we               = fill0;
            way1_we               = !fill0;
            meta_wdata[META_V0]   = v0 || fill0;
            meta_wdata[META_V1]   = v1 || !fill0;
            meta_wdata[META_LAST] = !fill0;
          end
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    cur_r      <= cur_nxt;
    out_word_r <= out_word_nxt;
    out_hit_r  <= out_hit_nxt;
  end

endmodule

`default_nettype wire

/* rtl/two_way_word_instruction_cache.sv */
`default_nettype none

`include "two_way_word_instruction_cache_defines.svh"

// Two-way set-associative read-only instruction cache, one 32-bit word per line,
// first-in first-out replacement per set. Each input item carries a byte address
// and the word memory holds there; each produces one result with the word and a
// hit flag. Accepted items wait in a two-entry queue; the back end pops one, reads
// tags, words and set metadata from synchronous memories with a registered read,
// then compares and fills, and pops no new item until it is through with the last.
// Each result is offered once the output is free. The registered read of the
// memories lies ahead of the compare-and-fill step. After reset the block clears
// the metadata memory one set per cycle, all 2^SET_INDEX_BITS sets (8192 by
// default), and accepts no item until then.
module two_way_word_instruction_cache #(
  parameter int SET_INDEX_BITS = twwic_pkg::SET_INDEX_BITS_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  twwic_fetch_if.sink    in_fetch,
  twwic_result_if.source out_result
);

  import twwic_pkg::*;

  localparam int TAG_W  = ADDR_W - OFFSET_BITS - SET_INDEX_BITS;
  localparam int WAY_W  = TAG_W + WORD_W;
  localparam int SETS   = 1 << SET_INDEX_BITS;

  front_stat_t               stat;
  back_ctl_t                 ctl;
  logic                      rd_en;
  logic [SET_INDEX_BITS-1:0] rd_addr;
  logic [SET_INDEX_BITS-1:0] wr_addr;
  logic                      meta_we;
  logic [META_W-1:0]         meta_wdata;
  logic [META_W-1:0]         meta_rdata;
  logic                      way0_we;
  logic                      way1_we;
  logic [WAY_W-1:0]          way_wdata;
  logic [WAY_W-1:0]          way0_rdata;
  logic [WAY_W-1:0]          way1_rdata;

  // Front end: accepts items into the queue.
  twwic_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fetch (in_fetch),
    .ctl      (ctl),
    .stat     (stat)
  );

  // Back end: lookup, compare, fill and result register.
  twwic_back #(
    .SET_INDEX_BITS (SET_INDEX_BITS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .stat       (stat),
    .ctl        (ctl),
    .out_result (out_result),
    .rd_en      (rd_en),
    .rd_addr    (rd_addr),
    .wr_addr    (wr_addr),
    .meta_we    (meta_we),
    .meta_wdata (meta_wdata),
    .meta_rdata (meta_rdata),
    .way0_we    (way0_we),
    .way1_we    (way1_we),
    .way_wdata  (way_wdata),
    .way0_rdata (way0_rdata),
    .way1_rdata (way1_rdata)
  );

  // Set metadata: valid bits and last filled way.
  twwic_ram #(.WIDTH(META_W), .DEPTH(SETS)) u_meta_ram (
    .clk   (clk),
    .we    (meta_we),
    .waddr (wr_addr),
    .wdata (meta_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (meta_rdata)
  );

  // Way 0 tag and word.
  twwic_ram #(.WIDTH(WAY_W), .DEPTH(SETS)) u_way0_ram (
    .clk   (clk),
    .we    (way0_we),
    .waddr (wr_addr),
    .wdata (way_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (way0_rdata)
  );

  // Way 1 tag and word.
  twwic_ram #(.WIDTH(WAY_W), .DEPTH(SETS)) u_way1_ram (
    .clk   (clk),
    .we    (way1_we),
    .waddr (wr_addr),
    .wdata (way_wdata),
    .re    (rd_en),
    .raddr (rd_addr),
    .rdata (way1_rdata)
  );

  // Consistency checks.
  `TWWIC_ASSERT_ALWAYS(a_reset_starts_clear, $past(!rst_n) |-> ctl.clearing, "clear pass did not start after reset")
  `TWWIC_ASSERT(a_no_accept_while_clear, ctl.clearing |-> !in_fetch.ready, "item accepted during clear pass")
  `TWWIC_ASSERT(a_fill_one_way, (meta_we && !ctl.clearing) |-> $onehot({way0_we, way1_we}), "fill must write exactly one way")
  `TWWIC_ASSERT(a_way_write_with_meta, (way0_we || way1_we) |-> (meta_we && !ctl.clearing), "way written without metadata update")

endmodule

`default_nettype wire

/* tb/sv/tb.sv */
`timescale 1ns / 1ps

module tb;
  import twwic_pkg::*;

  localparam int SET_BITS  = SET_INDEX_BITS_DEF;
  localparam int SET_COUNT = 1 << SET_BITS;
  localparam int TAG_LSB   = OFFSET_BITS + SET_BITS;
  localparam int TAG_W     = ADDR_W - TAG_LSB;
  localparam int POOL_SETS = 8;
  localparam int POOL_TAGS = 4;

  typedef struct {
    logic [WORD_W-1:0] read_word;
    logic              was_hit;
  } fetch_result_t;

  logic clk;
  logic rst_n;

  twwic_fetch_if  in_fetch();
  twwic_result_if out_result();

  two_way_word_instruction_cache u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_fetch  (in_fetch),
    .out_result(out_result)
  );

  // Shadow copy of the cache contents and per-set replacement order.
  logic [TAG_W-1:0]  shadow_tag  [2][SET_COUNT];
  logic [WORD_W-1:0] shadow_word [2][SET_COUNT];
  bit   [1:0]        shadow_valid[SET_COUNT];
  bit                shadow_last [SET_COUNT];

  fetch_t        pending_fetches[$];
  fetch_result_t expected_results[$];

  int gap_left;
  int burst_left;
  bit bursty;
  int hold_request;
  int hold_left;
  int rx_cycle;
  int error_count;

  logic [SET_BITS-1:0] pool_set[POOL_SETS];
  logic [TAG_W-1:0]    pool_tag[POOL_SETS][POOL_TAGS];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Looks up one fetch, fills on a miss, and returns the word the cache should give.
  function automatic fetch_result_t cache_lookup(input fetch_t f);
    logic [SET_BITS-1:0] set_idx;
    logic [TAG_W-1:0]    tag;
    bit                  fill_way;
    fetch_result_t       r;
    set_idx = f.fetch_address[TAG_LSB-1:OFFSET_BITS];
    tag     = f.fetch_address[ADDR_W-1:TAG_LSB];
    // Way 0 is checked first, so it would win a double match.
    for (int w = 0; w < 2; w++) begin
      if (shadow_valid[set_idx][w] && shadow_tag[w][set_idx] == tag) begin
        r.read_word = shadow_word[w][set_idx];
        r.was_hit   = 1'b1;
        return r;
      end
    end
    // Invalid ways fill first; otherwise replace the way not filled last.
    if (!shadow_valid[set_idx][0]) begin
      fill_way = 1'b0;
    end else if (!shadow_valid[set_idx][1]) begin
      fill_way = 1'b1;
    end else begin
      fill_way = !shadow_last[set_idx];
    end
    shadow_tag[fill_way][set_idx]  = tag;
    shadow_word[fill_way][set_idx] = f.memory_word;
    shadow_valid[set_idx][fill_way] = 1'b1;
    shadow_last[set_idx]            = fill_way;
    r.read_word = f.memory_word;
    r.was_hit   = 1'b0;
    return r;
  endfunction

  function automatic logic [ADDR_W-1:0] make_addr(input logic [TAG_W-1:0] tag,
                                                  input logic [SET_BITS-1:0] set_idx,
                                                  input logic [OFFSET_BITS-1:0] low);
    return {tag, set_idx, low};
  endfunction

  // Fetch driver: offers the oldest pending item, with gaps between bursts.
  always @(negedge clk) begin
    if (!rst_n || gap_left > 0 || pending_fetches.size() == 0) begin
      in_fetch.valid <= 1'b0;
    end else begin
      in_fetch.valid         <= 1'b1;
      in_fetch.fetch_address <= pending_fetches[0].fetch_address;
      in_fetch.memory_word   <= pending_fetches[0].memory_word;
    end
    if (gap_left > 0) gap_left--;
  end

  // Result receiver: a long hold when asked for, otherwise a rotating stall pattern.
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left    = hold_request;
      hold_request = 0;
    end
    rx_cycle++;
    if (hold_left > 0) begin
      hold_left--;
      out_result.ready <= 1'b0;
    end else begin
      case ((rx_cycle / 64) % 4)
        0: out_result.ready <= 1'b1;
        1: out_result.ready <= ($urandom_range(0, 3) != 0);
        2: out_result.ready <= ((rx_cycle % 5) >= 3);
        default: out_result.ready <= 1'($urandom_range(0, 1));
      endcase
    end
  end

  // Checks each result against the oldest expectation, then predicts accepted items.
  always @(posedge clk) begin : monitor
    fetch_result_t exp_r;
    fetch_t        f;
    if (rst_n) begin
      if (out_result.valid && out_result.ready) begin
        if (expected_results.size() == 0) begin
          $error("unexpected result: read_word %h was_hit %b",
                 out_result.read_word, out_result.was_hit);
          error_count++;
        end else begin
          exp_r = expected_results.pop_front();
          if (out_result.read_word !== exp_r.read_word) begin
            $error("read_word: expected %h, got %h", exp_r.read_word, out_result.read_word);
            error_count++;
          end
          if (out_result.was_hit !== exp_r.was_hit) begin
            $error("was_hit: expected %b, got %b", exp_r.was_hit, out_result.was_hit);
            error_count++;
          end
        end
      end
      if (in_fetch.valid && in_fetch.ready) begin
        f.fetch_address = in_fetch.fetch_address;
        f.memory_word   = in_fetch.memory_word;
        void'(pending_fetches.pop_front());
        expected_results.push_back(cache_lookup(f));
        if (bursty) begin
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            gap_left   = $urandom_range(1, 6);
            burst_left = $urandom_range(1, 16);
          end
        end
      end
    end
  end

  // Queues one item and keeps the sender at most a few items ahead of the block.
  task automatic send_fetch(input logic [ADDR_W-1:0] addr, input logic [WORD_W-1:0] word);
    fetch_t f;
    f.fetch_address = addr;
    f.memory_word   = word;
    pending_fetches.push_back(f);
    while (pending_fetches.size() > 2) @(posedge clk);
  endtask

  task automatic wait_drained();
    while (pending_fetches.size() != 0 || expected_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [ADDR_W-1:0] pick_address();
    int si;
    if ($urandom_range(0, 99) < 8) return $urandom;
    si = $urandom_range(0, POOL_SETS - 1);
    return make_addr(pool_tag[si][$urandom_range(0, POOL_TAGS - 1)], pool_set[si],
                     OFFSET_BITS'($urandom_range(0, 3)));
  endfunction

  // First fill of a set, then hits that ignore the low address bits.
  task automatic test_fill_and_hit();
    send_fetch(32'h0000_0000, 32'h1234_5678);
    send_fetch(32'h0000_0000, 32'hDEAD_BEEF);
    send_fetch(32'h0000_0003, 32'h0BAD_F00D);
    send_fetch(32'h0000_0002, 32'hCAFE_0001);
  endtask

  // All-ones and all-zero addresses and words, including the top set and tag.
  task automatic test_field_extremes();
    send_fetch(32'hFFFF_FFFF, 32'h0000_0000);
    send_fetch(32'hFFFF_FFFC, 32'hFFFF_FFFF);
    send_fetch(make_addr('0, '1, 2'd0), 32'hFFFF_FFFF);
    send_fetch(make_addr('1, '0, 2'd1), 32'h0000_0000);
    send_fetch(make_addr('0, '1, 2'd3), 32'h5555_5555);
  endtask

  // Three tags fighting over one set: replacement must be first-in first-out.
  task automatic test_fifo_replacement();
    logic [SET_BITS-1:0] s;
    logic [TAG_W-1:0]    tag_a;
    logic [TAG_W-1:0]    tag_b;
    logic [TAG_W-1:0]    tag_c;
    s     = 13'h0AAA;
    tag_a = 17'h15555;
    tag_b = 17'h0AAAA;
    tag_c = 17'h1FFFE;
    send_fetch(make_addr(tag_a, s, 2'd0), 32'hA000_0001);
    send_fetch(make_addr(tag_b, s, 2'd1), 32'hB000_0001);
    send_fetch(make_addr(tag_a, s, 2'd2), 32'h0000_0000);
    send_fetch(make_addr(tag_b, s, 2'd3), 32'h0000_0000);
    send_fetch(make_addr(tag_c, s, 2'd0), 32'hC000_0001);
    send_fetch(make_addr(tag_b, s, 2'd0), 32'h0000_0000);
    send_fetch(make_addr(tag_a, s, 2'd0), 32'hA000_0002);
    send_fetch(make_addr(tag_c, s, 2'd0), 32'h0000_0000);
    send_fetch(make_addr(tag_b, s, 2'd0), 32'hB000_0002);
    send_fetch(make_addr(tag_a, s, 2'd0), 32'h0000_0000);
    send_fetch(make_addr(tag_c, s, 2'd0), 32'hC000_0002);
    send_fetch(make_addr(tag_b, s, 2'd0), 32'h0000_0000);
  endtask

  // The receiver holds off long enough for the block to stall its input.
  task automatic test_input_stall();
    hold_request = 300;
    repeat (24) send_fetch(pick_address(), $urandom);
  endtask

  task automatic test_random_traffic(input int count, input bit with_gaps);
    bursty     = with_gaps;
    burst_left = $urandom_range(1, 16);
    repeat (count) send_fetch(pick_address(), $urandom);
  endtask

  initial begin
    rst_n                  = 1'b0;
    in_fetch.valid         = 1'b0;
    in_fetch.fetch_address = '0;
    in_fetch.memory_word   = '0;
    out_result.ready       = 1'b0;
    gap_left               = 0;
    burst_left             = 0;
    bursty                 = 1'b0;
    hold_request           = 0;
    hold_left              = 0;
    rx_cycle               = 0;
    error_count            = 0;

    // A few sets and tags so that random traffic hits and evicts often.
    pool_set[0] = '0;
    pool_set[1] = '1;
    for (int i = 2; i < POOL_SETS; i++) pool_set[i] = SET_BITS'($urandom);
    for (int i = 0; i < POOL_SETS; i++) begin
      for (int j = 0; j < POOL_TAGS; j++) pool_tag[i][j] = TAG_W'($urandom);
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_fill_and_hit();
    test_field_extremes();
    test_fifo_replacement();
    wait_drained();
    test_input_stall();
    wait_drained();
    test_random_traffic(150, 1'b0);
    wait_drained();
    test_random_traffic(700, 1'b1);
    wait_drained();
    bursty = 1'b0;

    repeat (10) @(posedge clk);
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

  // Run limit: covers the clearing pass after reset with a wide margin.
  initial begin
    #3_000_000;
    $display("tb: done, errors");
    $finish;
  end

endmodule
